### hdl/ales_pkg.sv
// Shared types, register map and reset constants for the axis limit and encoder supervisor.
package ales_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned ADDR_BITS      = 5;
  localparam int unsigned DATA_BITS      = 32;

  localparam logic [7:0]  CLEAR_DELAY_RST = 8'd100;

  typedef enum logic [2:0] {
    REG_XY_LEVEL  = 3'd0,
    REG_Z_LEVEL   = 3'd1,
    REG_Z_TARGET  = 3'd2,
    REG_Z_TGT_EN  = 3'd3,
    REG_Z_CLR_DLY = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        xy_active_level;
    logic        z_active_level;
    logic [15:0] z_target;
    logic        z_target_enable;
    logic [7:0]  z_clear_delay;
  } cfg_t;

  typedef struct packed {
    logic x_max_pin;
    logic x_min_pin;
    logic y_max_pin;
    logic y_min_pin;
    logic z_high_pin;
    logic z_low_pin;
    logic z_encoder_pin;
    logic z_going_down;
    logic z_drive_on;
    logic protect_tick;
  } in_item_t;

  typedef struct packed {
    logic               x_stop;
    logic               y_stop;
    logic               z_stop;
    logic signed [15:0] z_position;
    logic               stall_alarm;
  } out_item_t;

endpackage

### hdl/ales_core.sv
// Supervisor state and single-pass step logic for one scan tick.
module ales_core #(
  parameter int unsigned COUNT_BITS = ales_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ales_pkg::cfg_t     cfg_i,
  input  ales_pkg::in_item_t item_i,
  output ales_pkg::out_item_t result_o
);
  import ales_pkg::*;

  localparam int unsigned SEEN_XMAX = 0;
  localparam int unsigned SEEN_XMIN = 1;
  localparam int unsigned SEEN_YMAX = 2;
  localparam int unsigned SEEN_YMIN = 3;
  localparam int unsigned SEEN_ZMAX = 4;
  localparam int unsigned SEEN_ZMIN = 5;

  logic [5:0]            seen_q, seen_d;
  logic                  enc_q, enc_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  guard_q, guard_d;
  logic [7:0]            cd_q, cd_d;

  logic [7:0]             cd_dec;
  logic [COUNT_BITS-1:0]  cnt_clr;
  logic [COUNT_BITS+15:0] tgt_ext;
  logic [COUNT_BITS+15:0] pos_ext;
  logic                   act_xmax, act_xmin, act_ymax, act_ymin, act_zmax, act_zmin;
  logic                   ev_xmax, ev_xmin, ev_ymax, ev_ymin, ev_zmax, ev_zmin;
  logic                   enc_chg, tgt_hit, zsw, zs, guard_enc, guard_zs, alarm;

  assign act_xmax = item_i.x_max_pin  == cfg_i.xy_active_level;
  assign act_xmin = item_i.x_min_pin  == cfg_i.xy_active_level;
  assign act_ymax = item_i.y_max_pin  == cfg_i.xy_active_level;
  assign act_ymin = item_i.y_min_pin  == cfg_i.xy_active_level;
  assign act_zmax = item_i.z_high_pin == cfg_i.z_active_level;
  assign act_zmin = item_i.z_low_pin  == cfg_i.z_active_level;

  assign ev_xmax = act_xmax && !seen_q[SEEN_XMAX];
  assign ev_xmin = !ev_xmax && act_xmin && !seen_q[SEEN_XMIN];
  assign ev_ymax = act_ymax && !seen_q[SEEN_YMAX];
  assign ev_ymin = !ev_ymax && act_ymin && !seen_q[SEEN_YMIN];
  assign ev_zmax = act_zmax && !seen_q[SEEN_ZMAX];
  assign ev_zmin = !ev_zmax && act_zmin && !seen_q[SEEN_ZMIN];

  assign tgt_ext = {{COUNT_BITS{cfg_i.z_target[15]}}, cfg_i.z_target};
  assign cd_dec  = (cd_q != 8'd0) ? cd_q - 8'd1 : 8'd0;
  assign cnt_clr = (cd_q == 8'd1) ? '0 : cnt_q;
  assign enc_chg = item_i.z_encoder_pin != enc_q;
  assign zsw     = ev_zmax || ev_zmin;

  always_comb begin
    seen_d            = seen_q;
    seen_d[SEEN_XMAX] = act_xmax;
    seen_d[SEEN_YMAX] = act_ymax;
    seen_d[SEEN_ZMAX] = act_zmax;
    if (!ev_xmax) begin
      seen_d[SEEN_XMIN] = act_xmin;
    end
    if (!ev_ymax) begin
      seen_d[SEEN_YMIN] = act_ymin;
    end
    if (!ev_zmax) begin
      seen_d[SEEN_ZMIN] = act_zmin;
    end
  end

  always_comb begin
    enc_d     = item_i.z_encoder_pin;
    cnt_d     = cnt_clr;
    guard_enc = guard_q;
    if (enc_chg) begin
      guard_enc = 1'b0;
      if (item_i.z_going_down) begin
        cnt_d = cnt_clr + 1'b1;
      end else begin
        cnt_d = cnt_clr - 1'b1;
      end
    end
  end

  assign tgt_hit  = enc_chg && cfg_i.z_target_enable && (tgt_ext[COUNT_BITS-1:0] == cnt_d);
  assign zs       = tgt_hit || zsw;
  assign guard_zs = zs ? 1'b0 : guard_enc;

  always_comb begin
    cd_d = cd_dec;
    if (zsw && act_zmax) begin
      cd_d = (cfg_i.z_clear_delay == 8'd0) ? 8'd1 : cfg_i.z_clear_delay;
    end
  end

  always_comb begin
    alarm   = 1'b0;
    guard_d = guard_zs;
    if (item_i.protect_tick) begin
      if (item_i.z_drive_on) begin
        alarm   = guard_zs;
        guard_d = !guard_zs;
      end else begin
        guard_d = 1'b0;
      end
    end
  end

  assign pos_ext = {16'd0, cnt_d};

  always_comb begin
    result_o.x_stop      = ev_xmax || ev_xmin;
    result_o.y_stop      = ev_ymax || ev_ymin;
    result_o.z_stop      = zs;
    result_o.z_position  = pos_ext[15:0];
    result_o.stall_alarm = alarm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      enc_q   <= 1'b0;
      cnt_q   <= '0;
      guard_q <= 1'b0;
      cd_q    <= 8'd0;
    end else if (step_i) begin
      seen_q  <= seen_d;
      enc_q   <= enc_d;
      cnt_q   <= cnt_d;
      guard_q <= guard_d;
      cd_q    <= cd_d;
    end
  end

endmodule

### hdl/ales_obuf.sv
// Two-entry result buffer between the step logic and the output channel.
module ales_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 ready_o,
  input  ales_pkg::out_item_t  data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ales_pkg::out_item_t  data_o
);
  import ales_pkg::*;

  out_item_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign ready_o = cnt_q != 2'd2;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

endmodule

### hdl/axis_limit_encoder_supervisor_unit.sv
// Top level of the axis limit and encoder supervisor with its register port.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  config  | in        | psel/penable/pwrite     | paddr, pwdata, prdata
//  in      | in        | in_valid_i / in_ready_o | in_data_i (in_item_t)
//  out     | out       | out_valid_o/out_ready_i | out_data_o (out_item_t)
//
// One item per cycle unless in_ready_o is low: each step is one logic pass from the state registers.
// Results are registered on acceptance into a two-entry output buffer.
// in_ready_o drops only while both buffer entries hold undelivered results.
// Reset is asynchronous; all state but the buffer data resets and no clearing pass is needed.
module axis_limit_encoder_supervisor_unit #(
  parameter int unsigned COUNT_BITS = ales_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ales_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [ales_pkg::DATA_BITS-1:0]      pwdata,
  output logic [ales_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ales_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ales_pkg::out_item_t                 out_data_o
);
  import ales_pkg::*;

  cfg_t      cfg_q, cfg_d;
  reg_idx_e  reg_idx;
  logic      wr_en;
  logic      step;
  out_item_t result;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign step    = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    case (reg_idx)
      REG_XY_LEVEL:  cfg_d.xy_active_level = pwdata[0];
      REG_Z_LEVEL:   cfg_d.z_active_level  = pwdata[0];
      REG_Z_TARGET:  cfg_d.z_target        = pwdata[15:0];
      REG_Z_TGT_EN:  cfg_d.z_target_enable = pwdata[0];
      REG_Z_CLR_DLY: cfg_d.z_clear_delay   = pwdata[7:0];
      default:       cfg_d = cfg_q;
    endcase
  end

  always_comb begin
    case (reg_idx)
      REG_XY_LEVEL:  prdata = {31'd0, cfg_q.xy_active_level};
      REG_Z_LEVEL:   prdata = {31'd0, cfg_q.z_active_level};
      REG_Z_TARGET:  prdata = {16'd0, cfg_q.z_target};
      REG_Z_TGT_EN:  prdata = {31'd0, cfg_q.z_target_enable};
      REG_Z_CLR_DLY: prdata = {24'd0, cfg_q.z_clear_delay};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xy_active_level <= 1'b1;
      cfg_q.z_active_level  <= 1'b0;
      cfg_q.z_target        <= 16'd0;
      cfg_q.z_target_enable <= 1'b0;
      cfg_q.z_clear_delay   <= CLEAR_DELAY_RST;
    end else if (wr_en) begin
      cfg_q <= cfg_d;
    end
  end

  ales_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg_q),
    .item_i   (in_data_i),
    .result_o (result)
  );

  ales_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .ready_o (in_ready_o),
    .data_i  (result),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

### hdl/ales_checker.sv
// Port-level checks for the supervisor and their binding to the top level.
module ales_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ales_pkg::out_item_t out_data_o
);
  import ales_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_full_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_accept_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

endmodule

bind axis_limit_encoder_supervisor_unit ales_checker u_ales_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### verif/tb_axis_limit_encoder_supervisor_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the axis limit and encoder supervisor: queued scan items, predicted results.
module tb_axis_limit_encoder_supervisor_unit;
  import ales_pkg::*;

  localparam int unsigned WDOG_LIMIT = 2000;

  localparam int unsigned BIT_XMAX = 0;
  localparam int unsigned BIT_XMIN = 1;
  localparam int unsigned BIT_YMAX = 2;
  localparam int unsigned BIT_YMIN = 3;
  localparam int unsigned BIT_ZMAX = 4;
  localparam int unsigned BIT_ZMIN = 5;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [ADDR_BITS-1:0] paddr       = '0;
  logic [DATA_BITS-1:0] pwdata      = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;

  axis_limit_encoder_supervisor_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  logic        lvl_xy   = 1'b1;
  logic        lvl_z    = 1'b0;
  logic [15:0] tgt      = '0;
  logic        tgt_en   = 1'b0;
  logic [7:0]  clr_dly  = CLEAR_DELAY_RST;

  logic [5:0]  limit_mem = '0;
  logic        enc_mem   = 1'b0;
  logic [15:0] zcount    = '0;
  logic        guard     = 1'b0;
  logic [7:0]  clr_cnt   = '0;

  in_item_t    scan_q[$];
  out_item_t   result_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors         = 0;
  int unsigned wdog           = 0;

  logic [5:0]  sw_pins = '0;
  logic        enc_pin = 1'b0;
  logic        enc_run = 1'b0;
  logic        go_down = 1'b0;
  logic        drive   = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic sw_event(input logic pin, input logic lvl, input int unsigned pos);
    if (pin == lvl) begin
      if (!limit_mem[pos]) begin
        limit_mem[pos] = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    limit_mem[pos] = 1'b0;
    return 1'b0;
  endfunction

  function automatic out_item_t predict_step(input in_item_t it);
    out_item_t r;
    logic      zsw;
    r = '0;
    if (clr_cnt != 8'd0) begin
      clr_cnt = clr_cnt - 8'd1;
      if (clr_cnt == 8'd0) zcount = '0;
    end
    // min switch is only looked at when max gave no event
    r.x_stop = sw_event(it.x_max_pin, lvl_xy, BIT_XMAX);
    if (!r.x_stop) r.x_stop = sw_event(it.x_min_pin, lvl_xy, BIT_XMIN);
    r.y_stop = sw_event(it.y_max_pin, lvl_xy, BIT_YMAX);
    if (!r.y_stop) r.y_stop = sw_event(it.y_min_pin, lvl_xy, BIT_YMIN);
    if (it.z_encoder_pin != enc_mem) begin
      enc_mem = it.z_encoder_pin;
      zcount  = it.z_going_down ? zcount + 16'd1 : zcount - 16'd1;
      guard   = 1'b0;
      if (tgt_en && tgt == zcount) r.z_stop = 1'b1;
    end
    zsw = sw_event(it.z_high_pin, lvl_z, BIT_ZMAX);
    if (!zsw) zsw = sw_event(it.z_low_pin, lvl_z, BIT_ZMIN);
    if (zsw) begin
      r.z_stop = 1'b1;
      if (it.z_high_pin == lvl_z) clr_cnt = (clr_dly == 8'd0) ? 8'd1 : clr_dly;
    end
    if (r.z_stop) guard = 1'b0;
    if (it.protect_tick) begin
      if (it.z_drive_on) begin
        if (guard) begin
          r.stall_alarm = 1'b1;
          guard = 1'b0;
        end else begin
          guard = 1'b1;
        end
      end else begin
        guard = 1'b0;
      end
    end
    r.z_position = zcount;
    return r;
  endfunction

  function automatic in_item_t gen_scan();
    logic tick;
    if ($urandom_range(99) < 15) return in_item_t'($urandom_range(0, 1023));
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(99) < 8) sw_pins[k] = ~sw_pins[k];
    end
    if ($urandom_range(99) < 4) enc_run = ~enc_run;
    if (enc_run && $urandom_range(1)) enc_pin = ~enc_pin;
    if ($urandom_range(99) < 3) go_down = ~go_down;
    if ($urandom_range(99) < 8) drive = ~drive;
    tick = ($urandom_range(99) < 20);
    return in_item_t'({sw_pins, enc_pin, go_down, drive, tick});
  endfunction

  task automatic set_reg(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_XY_LEVEL:  lvl_xy  = val[0];
      REG_Z_LEVEL:   lvl_z   = val[0];
      REG_Z_TARGET:  tgt     = val[15:0];
      REG_Z_TGT_EN:  tgt_en  = val[0];
      REG_Z_CLR_DLY: clr_dly = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic xy, input logic z, input logic [15:0] t, input logic en,
                         input logic [7:0] dly);
    set_reg(REG_XY_LEVEL, {31'd0, xy});
    set_reg(REG_Z_LEVEL, {31'd0, z});
    set_reg(REG_Z_TARGET, {16'd0, t});
    set_reg(REG_Z_TGT_EN, {31'd0, en});
    set_reg(REG_Z_CLR_DLY, {24'd0, dly});
  endtask

  task automatic wait_drain();
    do @(posedge clk_i); while (scan_q.size() != 0 || in_valid_i || result_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n, input int unsigned idle, input int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) scan_q.push_back(gen_scan());
    wait_drain();
  endtask

  // Encoder moves on every item with the Z switches released, to wrap the count.
  task automatic run_sweep(input int unsigned n, input logic dn, input int unsigned idle,
                           input int unsigned stall);
    in_item_t it;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      it = gen_scan();
      enc_pin = ~enc_pin;
      it.z_encoder_pin = enc_pin;
      it.z_going_down  = dn;
      it.z_high_pin    = ~lvl_z;
      it.z_low_pin     = ~lvl_z;
      scan_q.push_back(it);
    end
    wait_drain();
  endtask

  task automatic check_field(input string fname, input int e, input int a);
    if (e != a) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, fname, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) result_q.push_back(predict_step(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (scan_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= scan_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : mon
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected result item: expected none, got %h", $time, out_data_o);
          errors++;
        end else begin
          e = result_q.pop_front();
          check_field("x_stop", e.x_stop, out_data_o.x_stop);
          check_field("y_stop", e.y_stop, out_data_o.y_stop);
          check_field("z_stop", e.z_stop, out_data_o.z_stop);
          check_field("z_position", e.z_position, out_data_o.z_position);
          check_field("stall_alarm", e.stall_alarm, out_data_o.stall_alarm);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("tb_axis_limit_encoder_supervisor_unit NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int t;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // x_max x_min y_max y_min z_high z_low enc down drive tick
    scan_q.push_back(in_item_t'(10'b00_00_00_0000));
    scan_q.push_back(in_item_t'(10'b11_11_11_1111));
    scan_q.push_back(in_item_t'(10'b11_11_11_1011));
    scan_q.push_back(in_item_t'(10'b10_01_11_0011));
    scan_q.push_back(in_item_t'(10'b10_01_11_0011));
    scan_q.push_back(in_item_t'(10'b01_10_11_0001));
    scan_q.push_back(in_item_t'(10'b00_00_10_1111));
    scan_q.push_back(in_item_t'(10'b00_00_01_1111));
    scan_q.push_back(in_item_t'(10'b00_00_11_0100));
    scan_q.push_back(in_item_t'(10'b00_00_11_1001));
    scan_q.push_back(in_item_t'(10'b11_00_11_1011));
    scan_q.push_back(in_item_t'(10'b01_00_00_0011));
    scan_q.push_back(in_item_t'(10'b00_11_11_0011));
    scan_q.push_back(in_item_t'(10'b00_00_11_0010));
    wait_drain();

    set_all(1'b0, 1'b1, 16'd3, 1'b1, 8'd5);
    run_random(400, 0, 0);
    set_all(1'b1, 1'b0, 16'hFFFE, 1'b1, 8'd1);
    run_random(400, 50, 0);
    set_all(1'b0, 1'b0, 16'd0, 1'b0, 8'd255);
    run_random(400, 0, 50);
    t = int'($urandom_range(0, 12)) - 6;
    set_all(1'b1, 1'b1, t[15:0], 1'b1, 8'd0);
    run_random(400, 14, 14);

    set_reg(REG_Z_TARGET, 32'h0000_FFF0);
    set_reg(REG_Z_CLR_DLY, 32'd2);
    run_sweep(200, 1'b0, 0, 0);
    set_reg(REG_Z_TARGET, 32'h0000_8000);
    run_sweep(200, 1'b1, 14, 14);

    if (errors == 0) begin
      $display("tb_axis_limit_encoder_supervisor_unit OK");
    end else begin
      $display("tb_axis_limit_encoder_supervisor_unit NOT OK");
    end
    $finish;
  end

endmodule
